// ===== rtl/core/tcp_passive_open_tracker_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TCP_PASSIVE_OPEN_TRACKER_ASSERT_SVH
`define TCP_PASSIVE_OPEN_TRACKER_ASSERT_SVH
`define TPOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TPOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/tpot_pkg.sv =====
`default_nettype none
package tpot_pkg;
  localparam int SLOTS = 64;
  localparam int SW = $clog2(SLOTS);

  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_LISTEN = 2'd1;
  localparam logic [1:0] FN_SEGMENT = 2'd2;
  localparam logic [1:0] FN_RESERVED = 2'd3;

  localparam logic [1:0] PH_CLOSED = 2'd0;
  localparam logic [1:0] PH_LISTEN = 2'd1;
  localparam logic [1:0] PH_SYNRCVD = 2'd2;
  localparam logic [1:0] PH_ESTAB = 2'd3;

  localparam logic [2:0] ST_CREATED = 3'd0;
  localparam logic [2:0] ST_NO_FREE = 3'd1;
  localparam logic [2:0] ST_LISTENING = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_SILENT = 3'd4;
  localparam logic [2:0] ST_REPLY = 3'd5;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAGS_SYNACK = 8'h12;
  localparam logic [31:0] INITIAL_SEQ = 32'd1000;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  bind_slot;
    logic [15:0] bind_port;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] target_port;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [3:0]  header_words;
    logic [15:0] seg_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_id;
    logic        reply_valid;
    logic [31:0] reply_ip;
    logic [15:0] reply_dst_port;
    logic [15:0] reply_src_port;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [7:0]  reply_flags;
    logic [15:0] payload_len;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    in_item_t    item;
    logic [15:0] pay_len;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/tcp_passive_open_tracker.sv =====
`default_nettype none
// Passive-open TCP connection tracker with a 64-slot table. Requests enter a
// two-entry queue and are served one at a time. Listen and unknown requests
// go straight to execution without a table search. Create and segment
// requests scan the table from slot zero, a memory read and a compare per
// slot; a match then reads the slot context and executes, and a search that
// finds nothing executes directly. A result that is not popped holds the back
// end, and the input queue then fills and raises full. Each request yields
// exactly one result.
module tcp_passive_open_tracker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  tpot_pkg::in_item_t   in_data,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output tpot_pkg::out_item_t  out_data
);
  import tpot_pkg::*;

  logic q_valid, q_take;
  cmd_t q_cmd;

  tpot_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data, .q_valid, .q_take, .q_cmd
  );
  tpot_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_cmd, .out_empty, .out_pop, .out_data
  );
endmodule
`default_nettype wire

// ===== rtl/core/tpot_front.sv =====
`default_nettype none
module tpot_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  tpot_pkg::in_item_t   in_data,
  output logic                 q_valid,
  input  wire logic            q_take,
  output tpot_pkg::cmd_t       q_cmd
);
  import tpot_pkg::*;

  // Two-entry queue; payload length is worked out on the way in.
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [16:0] diff;
  cmd_t       c;

  always_comb begin
    diff = {1'b0, in_data.seg_len} - {11'd0, in_data.header_words, 2'b00};
    c.item = in_data;
    c.pay_len = diff[16] ? 16'd0 : diff[15:0];
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_push && !in_full) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_push && !in_full) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_push && !in_full} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/tpot_back.sv =====
`default_nettype none
module tpot_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_take,
  input  tpot_pkg::cmd_t       q_cmd,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output tpot_pkg::out_item_t  out_data
);
  import tpot_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMP = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  logic [SLOTS-1:0] used_r;
  // A slot that was never bound to a port matches port zero.
  logic [SLOTS-1:0] bound_r;
  logic [1:0]  phase_m [SLOTS];
  logic [15:0] port_m  [SLOTS];
  // Connection context memory: address, peer port, send seq, recv ack, last rx length.
  logic [31:0] addr_m [SLOTS];
  logic [31:0] sseq_m [SLOTS];
  logic [31:0] rack_m [SLOTS];
  logic [15:0] rport_m [SLOTS];
  logic [15:0] lrx_m  [SLOTS];

  logic [2:0]  st_r;
  cmd_t        cmd_r;
  logic [SW:0] idx_r;
  logic        hit_r;
  logic [15:0] rd_port_r;
  logic [1:0]  rd_ph_r;
  logic [31:0] rd_addr_r, rd_rack_r, rd_sseq_r;
  out_item_t   res_r;
  logic        res_v_r;

  logic [SW-1:0] cur;
  logic [SW-1:0] bslot;
  logic          cur_hit;
  logic [15:0]   cur_port;
  logic [31:0]   new_ack;
  out_item_t     o;
  logic          wr_syn, wr_ack, wr_est, lst_ok, fire;

  assign cur = idx_r[SW-1:0];
  assign bslot = cmd_r.item.bind_slot[SW-1:0];
  assign out_empty = !res_v_r;
  assign out_data = res_r;
  assign q_take = (st_r == S_IDLE) && q_valid;
  assign fire = (st_r == S_EXEC) && (!res_v_r || out_pop);
  assign cur_port = bound_r[cur] ? rd_port_r : 16'd0;

  always_comb begin
    if (cmd_r.item.func == FN_CREATE) cur_hit = !used_r[cur];
    else cur_hit = used_r[cur] && (cur_port == cmd_r.item.target_port);
  end

  always_comb begin
    new_ack = rd_rack_r + {16'd0, cmd_r.pay_len};
    lst_ok = used_r[bslot];
    wr_syn = hit_r && rd_ph_r == PH_LISTEN && (cmd_r.item.seg_flags & FLAG_SYN) != 8'd0;
    wr_ack = hit_r && rd_ph_r == PH_SYNRCVD && (cmd_r.item.seg_flags & FLAG_ACK) != 8'd0;
    wr_est = hit_r && rd_ph_r == PH_ESTAB && (cmd_r.item.seg_flags & FLAG_ACK) != 8'd0
             && cmd_r.pay_len != 16'd0;
    o = '0;
    o.status = ST_NO_MATCH;
    unique case (cmd_r.item.func)
      FN_CREATE: begin
        o.status = hit_r ? ST_CREATED : ST_NO_FREE;
        if (hit_r) o.slot_id = 6'(cur);
      end
      FN_LISTEN: begin
        if (lst_ok) begin
          o.status = ST_LISTENING;
          o.slot_id = cmd_r.item.bind_slot;
        end
      end
      FN_SEGMENT: begin
        if (hit_r) begin
          o.status = ST_SILENT;
          o.slot_id = 6'(cur);
          if (wr_syn) begin
            o.status = ST_REPLY;
            o.reply_valid = 1'b1;
            o.reply_ip = cmd_r.item.peer_ip;
            o.reply_dst_port = cmd_r.item.peer_port;
            o.reply_src_port = cmd_r.item.target_port;
            o.reply_seq = INITIAL_SEQ;
            o.reply_ack = cmd_r.item.seg_seq + 32'd1;
            o.reply_flags = FLAGS_SYNACK;
          end else if (wr_est) begin
            o.status = ST_REPLY;
            o.reply_valid = 1'b1;
            o.reply_ip = rd_addr_r;
            o.reply_dst_port = cmd_r.item.peer_port;
            o.reply_src_port = cmd_r.item.target_port;
            o.reply_seq = rd_sseq_r;
            o.reply_ack = new_ack;
            o.reply_flags = FLAG_ACK;
            o.payload_len = cmd_r.pay_len;
          end
        end
      end
      default: o.status = ST_NO_MATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_SCAN) rd_port_r <= port_m[cur];
    if (st_r == S_READ) begin
      rd_ph_r <= phase_m[cur];
      rd_addr_r <= addr_m[cur];
      rd_rack_r <= rack_m[cur];
      rd_sseq_r <= sseq_m[cur];
    end
    if (fire) begin
      res_r <= o;
      case (cmd_r.item.func)
        FN_CREATE: if (hit_r) begin
          phase_m[cur] <= PH_CLOSED;
          lrx_m[cur] <= 16'd0;
        end
        FN_LISTEN: if (lst_ok) begin
          port_m[bslot] <= cmd_r.item.bind_port;
          phase_m[bslot] <= PH_LISTEN;
        end
        FN_SEGMENT: begin
          if (wr_syn) begin
            phase_m[cur] <= PH_SYNRCVD;
            addr_m[cur] <= cmd_r.item.peer_ip;
            rport_m[cur] <= cmd_r.item.peer_port;
            rack_m[cur] <= cmd_r.item.seg_seq + 32'd1;
            sseq_m[cur] <= INITIAL_SEQ + 32'd1;
          end else if (wr_ack) begin
            phase_m[cur] <= PH_ESTAB;
          end else if (wr_est) begin
            rack_m[cur] <= new_ack;
            lrx_m[cur] <= cmd_r.pay_len;
          end
        end
        default: ;
      endcase
    end
    if (q_take) cmd_r <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      bound_r <= '0;
      idx_r <= '0;
      hit_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= fire || (res_v_r && !out_pop);
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            idx_r <= '0;
            hit_r <= 1'b0;
            st_r <= (q_cmd.item.func == FN_LISTEN || q_cmd.item.func == FN_RESERVED)
                    ? S_EXEC : S_SCAN;
          end
        end
        S_SCAN: st_r <= S_CMP;
        S_CMP: begin
          // Linear search, lowest index first; each slot takes a read step (S_SCAN) and a compare step (S_CMP).
          if (cur_hit) begin
            hit_r <= 1'b1;
            st_r <= S_READ;
          end else if (idx_r == (SW+1)'(SLOTS - 1)) begin
            st_r <= S_EXEC;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_READ: st_r <= S_EXEC;
        S_EXEC: begin
          if (fire) begin
            st_r <= S_IDLE;
            if (cmd_r.item.func == FN_CREATE && hit_r) used_r[cur] <= 1'b1;
            if (cmd_r.item.func == FN_LISTEN && lst_ok) bound_r[bslot] <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/tpot_checker.sv =====
`default_nettype none
`include "tcp_passive_open_tracker_assert.svh"
module tpot_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input tpot_pkg::out_item_t      out_data
);
  import tpot_pkg::*;

  `TPOT_ASSERT_IMPL(a_status_range, clk, rst_n, !out_empty, out_data.status <= ST_REPLY)
  `TPOT_ASSERT_IMPL(a_reply_status, clk, rst_n, !out_empty,
                    out_data.reply_valid == (out_data.status == ST_REPLY))
  `TPOT_ASSERT_IMPL(a_flags, clk, rst_n, !out_empty && out_data.reply_valid,
                    out_data.reply_flags == FLAGS_SYNACK || out_data.reply_flags == FLAG_ACK)
  `TPOT_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_data))
endmodule

bind tcp_passive_open_tracker tpot_checker u_tpot_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_data
);
`default_nettype wire
